// ===== rtl/hbp_pkg.sv =====
// Shared types, widths and constants of the harmonic band power block.
`timescale 1ns / 1ps

package hbp_pkg;

	// Field and register widths.
	localparam int DEG_W     = 11;
	localparam int DEG_EXT_W = DEG_W + 1;
	localparam int COEF_W    = 24;
	localparam int SQ_W      = 47;
	localparam int TERM_W    = 49;
	localparam int SUM_W     = 60;
	localparam int LL_W      = 22;
	localparam int POWER_W   = 63;

	// Degree scaling: sum * l(l+1) in two 30-bit halves, then long division.
	localparam int SUM_HALF  = 30;
	localparam int PA_W      = SUM_HALF + LL_W;
	localparam int PROD_W    = SUM_W + LL_W;
	localparam int DIVR_W    = DEG_W + 1;
	localparam int DIV_STEPS = PROD_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	// Scaling by 1/(2*pi): quotient in three 22-bit digits times a 46-bit constant.
	localparam int Q_CHUNK   = 22;
	localparam int Q_USED    = 3 * Q_CHUNK;
	localparam int INV_W     = 46;
	localparam int PB_W      = Q_CHUNK + INV_W;
	localparam int ACC_W     = Q_USED + INV_W;
	localparam int OUT_LSB   = 48;
	localparam logic [INV_W-1:0] INV_TWO_PI = 46'd44798133900177;

	// Degree limits.
	localparam int unsigned MAX_DEGREE_DEF = 2047;
	localparam logic [DEG_W-1:0] MAX_DEGREE_RESET = 11'd2047;

	// Controller states.
	typedef enum logic [3:0] {
		S_RUN,
		S_DRAIN,
		S_MA_HI,
		S_MA_LO,
		S_MA_ADD,
		S_DIV,
		S_MB_C2,
		S_MB_C1,
		S_MB_C0,
		S_MB_ADD,
		S_LOAD
	} state_t;

	// Back-end operations issued to the datapath.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LL,
		OP_MA_HI,
		OP_MA_LO,
		OP_MA_ADD,
		OP_DIV,
		OP_MB_C2,
		OP_MB_C1,
		OP_MB_C0,
		OP_MB_ADD,
		OP_LOAD
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             sum_en;
		logic             clear;
		logic             dbl;
		logic             finish;
		logic [DEG_W-1:0] degree;
		logic             last;
		op_t              op;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// ===== rtl/hbp_ctrl.sv =====
// Controller: degree and order counters, max degree register and back-end sequencer.
`timescale 1ns / 1ps

module hbp_ctrl #(
	parameter int unsigned MAX_DEGREE = hbp_pkg::MAX_DEGREE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cfg_write_en,
	input  logic [hbp_pkg::DEG_W-1:0]  cfg_write_data,
	input  hbp_pkg::status_t           status,
	output hbp_pkg::cmd_t              cmd
);
	import hbp_pkg::*;

	localparam logic [DEG_EXT_W-1:0] MaxDegExt = DEG_EXT_W'(MAX_DEGREE);

	state_t              state_q;
	state_t              state_next;
	logic [DEG_W-1:0]    max_degree_q;
	logic [DEG_W-1:0]    lmax;
	logic [DEG_W-1:0]    deg_cnt_q;
	logic [DEG_W-1:0]    order_cnt_q;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic                accept;
	logic                monopole;
	logic                deg_done;
	logic                last;

	// Effective highest degree: zero acts as one, values above the limit clamp.
	always_comb begin
		if (max_degree_q == '0) begin
			lmax = DEG_W'(1);
		end else if ({1'b0, max_degree_q} > MaxDegExt) begin
			lmax = MaxDegExt[DEG_W-1:0];
		end else begin
			lmax = max_degree_q;
		end
	end

	// Classification of the coefficient at the input.
	assign accept   = in_valid && (state_q == S_RUN);
	assign monopole = (deg_cnt_q == '0);
	assign deg_done = !monopole && (order_cnt_q >= deg_cnt_q);
	assign last     = (deg_cnt_q >= lmax);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_degree_q <= MAX_DEGREE_RESET;
		end else if (cfg_write_en) begin
			max_degree_q <= cfg_write_data;
		end
	end

	// Degree and order position within the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_cnt_q   <= '0;
			order_cnt_q <= '0;
		end else if (accept) begin
			if (monopole) begin
				deg_cnt_q   <= DEG_W'(1);
				order_cnt_q <= '0;
			end else if (!deg_done) begin
				order_cnt_q <= order_cnt_q + DEG_W'(1);
			end else begin
				order_cnt_q <= '0;
				deg_cnt_q   <= last ? '0 : (deg_cnt_q + DEG_W'(1));
			end
		end
	end

	// Division step counter, restarted just before the divide phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (state_q == S_DIV) begin
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
		end else begin
			div_cnt_q <= '0;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			S_RUN: begin
				if (accept && deg_done) begin
					state_next = S_DRAIN;
				end
			end
			S_DRAIN:  state_next = S_MA_HI;
			S_MA_HI:  state_next = S_MA_LO;
			S_MA_LO:  state_next = S_MA_ADD;
			S_MA_ADD: state_next = S_DIV;
			S_DIV: begin
				if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					state_next = S_MB_C2;
				end
			end
			S_MB_C2:  state_next = S_MB_C1;
			S_MB_C1:  state_next = S_MB_C0;
			S_MB_C0:  state_next = S_MB_ADD;
			S_MB_ADD: state_next = S_LOAD;
			S_LOAD: begin
				if (status.out_free) begin
					state_next = S_RUN;
				end
			end
			default:  state_next = S_RUN;
		endcase
	end

	// Outputs: input handshake and datapath commands.
	always_comb begin
		in_stall   = (state_q != S_RUN);
		cmd.sum_en = accept && !monopole;
		cmd.clear  = (order_cnt_q == '0);
		cmd.dbl    = (order_cnt_q != '0);
		cmd.finish = accept && deg_done;
		cmd.degree = deg_cnt_q;
		cmd.last   = last;
		case (state_q)
			S_DRAIN:  cmd.op = OP_LL;
			S_MA_HI:  cmd.op = OP_MA_HI;
			S_MA_LO:  cmd.op = OP_MA_LO;
			S_MA_ADD: cmd.op = OP_MA_ADD;
			S_DIV:    cmd.op = OP_DIV;
			S_MB_C2:  cmd.op = OP_MB_C2;
			S_MB_C1:  cmd.op = OP_MB_C1;
			S_MB_C0:  cmd.op = OP_MB_C0;
			S_MB_ADD: cmd.op = OP_MB_ADD;
			S_LOAD:   cmd.op = OP_LOAD;
			default:  cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== rtl/hbp_datapath.sv =====
// Datapath: squares, saturating accumulator, degree scaling divider and output register.
`timescale 1ns / 1ps

module hbp_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [hbp_pkg::COEF_W-1:0]  coef_real,
	input  logic signed [hbp_pkg::COEF_W-1:0]  coef_imag,
	input  hbp_pkg::cmd_t                      cmd,
	output hbp_pkg::status_t                   status,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [hbp_pkg::DEG_W-1:0]          degree,
	output logic [hbp_pkg::POWER_W-1:0]        band_power,
	output logic                               frame_last
);
	import hbp_pkg::*;

	localparam logic [ACC_W:0] RndConst = (ACC_W + 1)'(1) << (OUT_LSB - 1);

	logic [COEF_W-1:0]   re_u;
	logic [COEF_W-1:0]   im_u;
	logic [COEF_W-1:0]   mag_re;
	logic [COEF_W-1:0]   mag_im;
	logic [SQ_W-1:0]     sq_re_s1;
	logic [SQ_W-1:0]     sq_im_s1;
	logic                valid_s1;
	logic                clear_s1;
	logic                dbl_s1;
	logic [TERM_W-1:0]   term;
	logic [SUM_W:0]      sum_total;
	logic [SUM_W-1:0]    sum_q;
	logic [DEG_W-1:0]    deg_q;
	logic                last_q;
	logic [LL_W-1:0]     ll_q;
	logic [SUM_HALF-1:0] mul_a;
	logic [PA_W-1:0]     pa_q;
	logic [PROD_W-1:0]   wide_q;
	logic [DIVR_W-1:0]   rem_q;
	logic [DIVR_W-1:0]   divisor;
	logic [DIVR_W:0]     div_cur;
	logic                div_ge;
	logic [Q_CHUNK-1:0]  mul_b;
	logic [PB_W-1:0]     pb_q;
	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W:0]      rnd;
	logic                sat;
	logic                load;

	// Magnitudes of the two parts; the most negative value maps to 2^23.
	assign re_u   = coef_real;
	assign im_u   = coef_imag;
	assign mag_re = re_u[COEF_W-1] ? (~re_u + COEF_W'(1)) : re_u;
	assign mag_im = im_u[COEF_W-1] ? (~im_u + COEF_W'(1)) : im_u;

	// Square stage, one multiplier per part.
	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			sq_re_s1 <= SQ_W'(mag_re) * SQ_W'(mag_re);
			sq_im_s1 <= SQ_W'(mag_im) * SQ_W'(mag_im);
			clear_s1 <= cmd.clear;
			dbl_s1   <= cmd.dbl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.sum_en;
		end
	end

	// Accumulate stage: orders above zero count twice, the sum saturates.
	always_comb begin
		term = TERM_W'(sq_re_s1) + TERM_W'(sq_im_s1);
		if (dbl_s1) begin
			term = term << 1;
		end
		sum_total = (clear_s1 ? '0 : {1'b0, sum_q}) + (SUM_W + 1)'(term);
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			sum_q <= sum_total[SUM_W] ? '1 : sum_total[SUM_W-1:0];
		end
	end

	// Degree and frame flag of the degree being finished.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			deg_q  <= cmd.degree;
			last_q <= cmd.last;
		end
		if (cmd.op == OP_LL) begin
			ll_q <= LL_W'(deg_q) * (LL_W'(deg_q) + LL_W'(1));
		end
	end

	// Product sum * l(l+1), upper half first, then the lower half shifted in.
	assign mul_a = (cmd.op == OP_MA_HI) ? sum_q[SUM_W-1:SUM_HALF] : sum_q[SUM_HALF-1:0];

	// Restoring division by 2l+1, one quotient bit per cycle into the same register.
	assign divisor = {deg_q, 1'b1};
	assign div_cur = {rem_q, wide_q[PROD_W-1]};
	assign div_ge  = (div_cur >= {1'b0, divisor});

	// Digit select for the 1/(2*pi) product, most significant digit first.
	always_comb begin
		case (cmd.op)
			OP_MB_C2: mul_b = wide_q[3*Q_CHUNK-1:2*Q_CHUNK];
			OP_MB_C1: mul_b = wide_q[2*Q_CHUNK-1:Q_CHUNK];
			default:  mul_b = wide_q[Q_CHUNK-1:0];
		endcase
	end

	// Back-end registers sequenced by the controller.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_MA_HI: begin
				pa_q <= PA_W'(mul_a) * PA_W'(ll_q);
			end
			OP_MA_LO: begin
				wide_q <= PROD_W'(pa_q);
				pa_q   <= PA_W'(mul_a) * PA_W'(ll_q);
			end
			OP_MA_ADD: begin
				wide_q <= (wide_q << SUM_HALF) + PROD_W'(pa_q);
				rem_q  <= '0;
			end
			OP_DIV: begin
				wide_q <= {wide_q[PROD_W-2:0], div_ge};
				rem_q  <= div_ge ? DIVR_W'(div_cur - {1'b0, divisor}) : div_cur[DIVR_W-1:0];
			end
			OP_MB_C2: begin
				pb_q <= PB_W'(mul_b) * PB_W'(INV_TWO_PI);
			end
			OP_MB_C1: begin
				acc_q <= ACC_W'(pb_q);
				pb_q  <= PB_W'(mul_b) * PB_W'(INV_TWO_PI);
			end
			OP_MB_C0: begin
				acc_q <= (acc_q << Q_CHUNK) + ACC_W'(pb_q);
				pb_q  <= PB_W'(mul_b) * PB_W'(INV_TWO_PI);
			end
			OP_MB_ADD: begin
				acc_q <= (acc_q << Q_CHUNK) + ACC_W'(pb_q);
			end
			default: begin
			end
		endcase
	end

	// Rounding and saturation; a quotient of 2^66 or more always saturates.
	assign rnd  = {1'b0, acc_q} + RndConst;
	assign sat  = (|wide_q[PROD_W-1:Q_USED]) || (|rnd[ACC_W:OUT_LSB+POWER_W]);
	assign load = (cmd.op == OP_LOAD) && status.out_free;

	// Output register, free when empty or when its beat is taken.
	assign status.out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			degree     <= deg_q;
			frame_last <= last_q;
			band_power <= sat ? '1 : rnd[OUT_LSB+POWER_W-1:OUT_LSB];
		end
	end

endmodule

// ===== rtl/harmonic_band_power.sv =====
// Top level of the harmonic band power block: controller and datapath.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake           | Beat contents
// coef      | in        | in_valid / in_stall | coef_real, coef_imag
// result    | out       | out_valid/out_stall | degree, band_power, frame_last
// config    | in        | cfg_write_en        | cfg_write_data (max_degree)
//
// A coefficient that does not close a degree does not hold the input; such beats stream back to back.
// The last coefficient of a degree holds the input while the back end runs a drain step, three
// multiply steps, 82 steps of the one-bit divider by 2l+1 and four scaling multiply steps,
// then one load into the output register; the load waits while an earlier result is stalled.
// Reset clears the counters, the sequencer and both valid flags and sets max_degree to 2047.
// Input is accepted again while the new result waits in the output register.

module harmonic_band_power #(
	parameter int unsigned MAX_DEGREE = hbp_pkg::MAX_DEGREE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [hbp_pkg::COEF_W-1:0]  coef_real,
	input  logic signed [hbp_pkg::COEF_W-1:0]  coef_imag,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [hbp_pkg::DEG_W-1:0]          degree,
	output logic [hbp_pkg::POWER_W-1:0]        band_power,
	output logic                               frame_last,
	input  logic                               cfg_write_en,
	input  logic [hbp_pkg::DEG_W-1:0]          cfg_write_data
);
	import hbp_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer and frame counters.
	hbp_ctrl #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.status         (status),
		.cmd            (cmd)
	);

	// Arithmetic and the output register.
	hbp_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef_real  (coef_real),
		.coef_imag  (coef_imag),
		.cmd        (cmd),
		.status     (status),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.degree     (degree),
		.band_power (band_power),
		.frame_last (frame_last)
	);

`ifndef ASSERT_OFF
	// A stalled result beat stays valid and unchanged.
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(degree) && $stable(band_power)
			&& $stable(frame_last))
		else $error("stalled result beat changed");

	// A new result only appears after the input was held for the back end.
	ap_load_after_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result loaded while input was open");

	// Closing a degree holds the input in the following cycle.
	ap_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> in_stall)
		else $error("input not held after the last coefficient of a degree");
`endif

endmodule

// ===== tb/harmonic_band_power_test.sv =====
// Self-checking testbench for the harmonic band power block.
`timescale 1ns / 1ps

module harmonic_band_power_test;
	import hbp_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 4000000;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned TAIL_CYCLES   = 100;
	localparam int unsigned LONG_HOLD     = 700;
	localparam int unsigned RANDOM_COEFS  = 500;
	localparam int unsigned CALM_TAIL     = 150;
	localparam int unsigned DUT_MAX_DEG   = MAX_DEGREE_DEF;

	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};

	// Scaling constants for the band power: round(2^48 / (2*pi)) and the saturation ceilings.
	localparam logic [45:0]        ONE_OVER_TWO_PI = 46'd44798133900177;
	localparam logic [SUM_W-1:0]   SUM_CEIL        = '1;
	localparam logic [POWER_W-1:0] POWER_CEIL      = '1;

	typedef enum {COEF_MIXED, COEF_MOST_NEG, COEF_MOST_POS} coef_kind_t;

	typedef struct {
		logic [DEG_W-1:0]   degree;
		logic [POWER_W-1:0] power;
		logic               last;
	} band_t;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     in_valid       = 1'b0;
	logic                     in_stall;
	logic signed [COEF_W-1:0] coef_real      = '0;
	logic signed [COEF_W-1:0] coef_imag      = '0;
	logic                     out_valid;
	logic                     out_stall      = 1'b0;
	logic [DEG_W-1:0]         degree;
	logic [POWER_W-1:0]       band_power;
	logic                     frame_last;
	logic                     cfg_write_en   = 1'b0;
	logic [DEG_W-1:0]         cfg_write_data = '0;

	// Band power model state: register copy, position in the frame and the open sum.
	logic [DEG_W-1:0] max_deg_reg = MAX_DEGREE_RESET;
	logic [DEG_W-1:0] deg_at      = '0;
	logic [DEG_W-1:0] ord_at      = '0;
	logic [SUM_W-1:0] sq_sum      = '0;
	band_t            pending_bands[$];

	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;
	bit          idle_on     = 1'b1;
	int unsigned gap_odds    = 6;
	bit          hold_req    = 1'b0;

	harmonic_band_power dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.coef_real      (coef_real),
		.coef_imag      (coef_imag),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.degree         (degree),
		.band_power     (band_power),
		.frame_last     (frame_last),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Exact square of a coefficient magnitude; the most negative value squares to 2^46.
	function automatic logic [2*COEF_W-1:0] coef_sq(input logic signed [COEF_W-1:0] v);
		logic [COEF_W-1:0]   mag;
		logic [2*COEF_W-1:0] sq;
		mag = v[COEF_W-1] ? (-v) : v;
		sq  = mag;
		sq  = sq * sq;
		return sq;
	endfunction

	// l(l+1)/(2*pi) * sum/(2l+1): exact integer quotient, then rounded scaling, saturating.
	function automatic logic [POWER_W-1:0] scaled_power(input logic [SUM_W-1:0] s,
			input logic [DEG_W-1:0] l);
		logic [127:0] lw;
		logic [127:0] sw;
		logic [127:0] quo;
		logic [127:0] acc;
		lw  = l;
		sw  = s;
		quo = (sw * (lw * (lw + 128'd1))) / (2 * lw + 128'd1);
		if (quo >= (128'd1 << 80))
			return POWER_CEIL;
		acc = quo * ONE_OVER_TWO_PI + (128'd1 << 47);
		if (acc >= (128'd1 << 111))
			return POWER_CEIL;
		return acc[110:48];
	endfunction

	// Advance the model by one accepted coefficient beat; a closed degree queues a band power.
	task automatic coef_beat(input logic signed [COEF_W-1:0] re, input logic signed [COEF_W-1:0] im);
		logic [DEG_W-1:0] lim;
		logic [63:0]      term;
		logic [63:0]      total;
		band_t            band;
		lim = max_deg_reg;
		if (lim == 0)
			lim = 1;
		if (lim > DUT_MAX_DEG)
			lim = DEG_W'(DUT_MAX_DEG);
		// The monopole only restarts the frame.
		if (deg_at == 0) begin
			deg_at = 1;
			ord_at = 0;
			sq_sum = '0;
			return;
		end
		term = coef_sq(re);
		term = term + coef_sq(im);
		if (ord_at != 0)
			term = term << 1;
		total = sq_sum + term;
		if (total > SUM_CEIL)
			total = SUM_CEIL;
		sq_sum = total[SUM_W-1:0];
		if (ord_at < deg_at) begin
			ord_at = ord_at + 1;
			return;
		end
		band.degree = deg_at;
		band.power  = scaled_power(sq_sum, deg_at);
		band.last   = (deg_at >= lim);
		pending_bands.push_back(band);
		sq_sum = '0;
		ord_at = '0;
		deg_at = band.last ? '0 : deg_at + 1;
	endtask

	function automatic logic signed [COEF_W-1:0] pick_coef(input coef_kind_t kind);
		logic [31:0]              word;
		logic signed [COEF_W-1:0] v;
		word = $urandom;
		v    = word[COEF_W-1:0];
		case (kind)
			COEF_MOST_NEG: v = COEF_MIN;
			COEF_MOST_POS: v = COEF_MAX;
			default: begin
				// Mostly full-range values, with the field extremes and small values mixed in.
				case ($urandom_range(11, 0))
					0: v = COEF_MIN;
					1: v = COEF_MAX;
					2: v = '0;
					3: v = '1;
					4: v = COEF_W'($urandom_range(255, 0));
					default: ;
				endcase
			end
		endcase
		return v;
	endfunction

	// Send one coefficient beat, after an optional idle burst, and hold it until accepted.
	task automatic offer_coef(input logic signed [COEF_W-1:0] re, input logic signed [COEF_W-1:0] im);
		int unsigned gap;
		gap = 0;
		if (idle_on && $urandom_range(gap_odds - 1, 0) == 0)
			gap = $urandom_range(11, 1);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		coef_real <= re;
		coef_imag <= im;
		do @(posedge clk); while (in_stall);
		coef_beat(re, im);
	endtask

	// Send whole degrees, every order of each, starting at the given degree.
	task automatic send_degrees(input int first_deg, input int last_deg, input coef_kind_t kind);
		for (int l = first_deg; l <= last_deg; l++) begin
			for (int m = 0; m <= l; m++)
				offer_coef(pick_coef(kind), pick_coef(kind));
		end
	endtask

	// Stop sending and let every pending band power and any work in flight come out.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bands.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_degree(input logic [DEG_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		max_deg_reg = value;
	endtask

	// Extreme coefficients under the reset maximum, then a lower maximum in mid-frame.
	task automatic test_directed_extremes();
		offer_coef(COEF_MAX, COEF_MIN);
		offer_coef(COEF_MIN, COEF_MIN);
		offer_coef(COEF_MAX, COEF_MAX);
		offer_coef('0, '0);
		offer_coef('1, 1);
		offer_coef(COEF_MIN, '0);
		repeat (4) offer_coef('0, '0);
		// Zero acts as one; the open degree 4 closes the frame.
		set_max_degree('0);
		send_degrees(4, 4, COEF_MIXED);
	endtask

	// Shortest frames: a monopole and one degree, under max degree zero and one.
	task automatic test_min_max_degree();
		send_degrees(0, 1, COEF_MOST_POS);
		set_max_degree(1);
		send_degrees(0, 1, COEF_MIXED);
	endtask

	// The receiver holds off for a long stretch while frames keep coming, then the sender drains.
	task automatic test_receiver_backpressure();
		set_max_degree(3);
		idle_on  = 1'b0;
		hold_req = 1'b1;
		repeat (4) send_degrees(0, 3, COEF_MIXED);
		wait_idle();
		idle_on = 1'b1;
		send_degrees(0, 3, COEF_MIXED);
	endtask

	// Climb to higher degrees under the widest maximum, with the largest magnitudes at the top.
	task automatic test_high_degrees();
		set_max_degree(DEG_W'(DUT_MAX_DEG));
		send_degrees(0, 15, COEF_MIXED);
		send_degrees(16, 19, COEF_MOST_NEG);
		// A small maximum ends the frame at the open degree.
		set_max_degree(5);
		send_degrees(20, 20, COEF_MIXED);
	endtask

	// Random coefficient stream in phases; most phases start under a new maximum or after a pause.
	task automatic test_random_stream();
		int unsigned sent;
		int unsigned pick;
		int unsigned phase_len;
		logic [DEG_W-1:0] setting;
		sent = 0;
		while (sent < RANDOM_COEFS) begin
			pick = $urandom_range(9, 0);
			if (pick < 6) begin
				case ($urandom_range(15, 0))
					0, 1:    setting = '0;
					2, 3:    setting = 1;
					4:       setting = DEG_W'(DUT_MAX_DEG);
					5:       setting = DEG_W'($urandom_range(40, 13));
					default: setting = DEG_W'($urandom_range(12, 2));
				endcase
				set_max_degree(setting);
			end else if (pick < 8) begin
				wait_idle();
			end
			if (sent + CALM_TAIL >= RANDOM_COEFS)
				idle_on = 1'b0;
			phase_len = $urandom_range(120, 20);
			repeat (phase_len) begin
				offer_coef(pick_coef(COEF_MIXED), pick_coef(COEF_MIXED));
				sent++;
			end
		end
	endtask

	// Receiver stall: random bursts, or one long hold on request.
	initial begin : result_stall
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				stall_left = LONG_HOLD;
				hold_req   = 1'b0;
			end else if (stall_left == 0 && idle_on && $urandom_range(7, 0) == 0) begin
				stall_left = $urandom_range(11, 1);
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// Compare each accepted result beat with the oldest pending band power.
	always @(posedge clk) begin : check_band
		band_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bands.size() == 0) begin
				mismatches++;
				$error("result beat with no band power pending: degree %0d", degree);
			end else begin
				want = pending_bands.pop_front();
				if (degree !== want.degree) begin
					mismatches++;
					$error("degree: expected %0d, actual %0d", want.degree, degree);
				end
				if (band_power !== want.power) begin
					mismatches++;
					$error("band_power: expected %0h, actual %0h", want.power, band_power);
				end
				if (frame_last !== want.last) begin
					mismatches++;
					$error("frame_last: expected %0b, actual %0b", want.last, frame_last);
				end
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : run_tests
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_extremes();
		test_min_max_degree();
		test_receiver_backpressure();
		test_high_degrees();
		test_random_stream();
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
